// ===== rtl/core/b2s_pkg.sv =====
// types, constants and helper functions shared by the blake2s engine
package b2s_pkg;

  typedef logic [31:0] word_t;

  // one set of mixing taps: a, b, c and d words
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  // mix unit control: which half of the g function, and first or second pass
  typedef struct packed {
    logic c_half;
    logic second;
  } mix_ctl_t;

  localparam int unsigned ROT_D1 = 16;
  localparam int unsigned ROT_B1 = 12;
  localparam int unsigned ROT_D2 = 8;
  localparam int unsigned ROT_B2 = 7;

  localparam logic [3:0] LAST_ROUND = 4'd9;
  localparam logic [5:0] DL_RESET   = 6'd32;
  localparam logic [5:0] DL_MAX     = 6'd32;

  localparam word_t IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // message schedule, one row per round
  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
      4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4,  4'd8,  4'd9,  4'd15, 4'd13, 4'd6,
      4'd1,  4'd12, 4'd0,  4'd2,  4'd11, 4'd7,  4'd5,  4'd3},
    '{4'd11, 4'd8,  4'd12, 4'd0,  4'd5,  4'd2,  4'd15, 4'd13,
      4'd10, 4'd14, 4'd3,  4'd6,  4'd7,  4'd1,  4'd9,  4'd4},
    '{4'd7,  4'd9,  4'd3,  4'd1,  4'd13, 4'd12, 4'd11, 4'd14,
      4'd2,  4'd6,  4'd5,  4'd10, 4'd4,  4'd0,  4'd15, 4'd8},
    '{4'd9,  4'd0,  4'd5,  4'd7,  4'd2,  4'd4,  4'd10, 4'd15,
      4'd14, 4'd1,  4'd11, 4'd12, 4'd6,  4'd8,  4'd3,  4'd13},
    '{4'd2,  4'd12, 4'd6,  4'd10, 4'd0,  4'd11, 4'd8,  4'd3,
      4'd4,  4'd13, 4'd7,  4'd5,  4'd15, 4'd14, 4'd1,  4'd9},
    '{4'd12, 4'd5,  4'd1,  4'd15, 4'd14, 4'd13, 4'd4,  4'd10,
      4'd0,  4'd7,  4'd6,  4'd3,  4'd9,  4'd2,  4'd8,  4'd11},
    '{4'd13, 4'd11, 4'd7,  4'd14, 4'd12, 4'd1,  4'd3,  4'd9,
      4'd5,  4'd0,  4'd15, 4'd4,  4'd8,  4'd6,  4'd2,  4'd10},
    '{4'd6,  4'd15, 4'd14, 4'd9,  4'd11, 4'd3,  4'd0,  4'd8,
      4'd12, 4'd2,  4'd13, 4'd7,  4'd1,  4'd4,  4'd10, 4'd5},
    '{4'd10, 4'd2,  4'd8,  4'd4,  4'd7,  4'd6,  4'd1,  4'd5,
      4'd15, 4'd11, 4'd9,  4'd14, 4'd3,  4'd12, 4'd13, 4'd0}
  };

  // digest length as used: zero acts as one, above the maximum acts as the maximum
  function automatic logic [5:0] eff_len(input logic [5:0] dl);
    logic [5:0] len;
    if (dl == 6'd0) begin
      len = 6'd1;
    end else if (dl > DL_MAX) begin
      len = DL_MAX;
    end else begin
      len = dl;
    end
    return len;
  endfunction

  // initial chain word, parameter word folded into word zero
  function automatic word_t iv_param(input logic [2:0] idx, input logic [5:0] len);
    word_t w;
    w = IV[idx];
    if (idx == 3'd0) begin
      w = w ^ {8'h01, 8'h01, 10'd0, len};
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/b2s_in_if.sv =====
// message word channel: valid/ready with one word and its byte count
interface b2s_in_if import b2s_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      message_word;
  logic [2:0] valid_bytes;
  logic       last_item;

  modport source (output valid, message_word, valid_bytes, last_item, input ready);
  modport sink   (input valid, message_word, valid_bytes, last_item, output ready);
endinterface

// ===== rtl/core/b2s_out_if.sv =====
// digest word channel: valid/ready with one hash word and its end marker
interface b2s_out_if import b2s_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t hash_word;
  logic  last_hash_word;

  modport source (output valid, hash_word, last_hash_word, input ready);
  modport sink   (input valid, hash_word, last_hash_word, output ready);
endinterface

// ===== rtl/core/blake2s_hash_engine_core.sv =====
// blake2s hash engine top level: byte packing, compression sequencer, digest output
//
// in_msg carries one little-endian message word with its count of valid bytes;
// a transfer with last_item set ends the message (zero bytes allowed).
// out_hash returns one word per started four bytes of the digest length,
// last_hash_word on the final one.
// The APB port holds the digest length at address 0; a write restarts the message.
// An item is taken only in the idle state; its bytes are then packed into the
// current buffer word, and into the next when they straddle a word boundary.
// A compression loads the chain value from its memory, runs the 80 g steps on
// the one shared mix unit (each step as a first and a second pass of its a/d and
// c/b halves, paced by the one read port of the message memory and the add chain
// of a half step), and folds the result back. A full block is compressed when
// the next byte arrives. After the last item each digest word is read from the
// chain memory and then loaded into the output register.
// The next message is accepted while the last digest word still waits; a stalled
// receiver holds the engine in its output phase.
// Reset and configuration writes need no clearing pass: until the first
// compression writes the chain memory it reads as the initial vector.
module blake2s_hash_engine_core import b2s_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  b2s_in_if.sink            in_msg,
  b2s_out_if.source         out_hash,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic REG_DIGEST_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_INIT,
    S_MIX,
    S_FOLD,
    S_ERD,
    S_ELD
  } state_t;

  state_t      state_r;
  logic [5:0]  dl_r;
  logic        fresh_r;
  logic [63:0] ctr_r;
  logic [6:0]  buf_r;
  logic        final_r;
  word_t       item_word_r;
  logic [2:0]  rem_r;
  logic        last_r;
  word_t       pend_r;
  logic [3:0]  step_r;
  logic [1:0]  phase_r;
  logic [2:0]  g_r;
  logic [3:0]  round_r;
  logic [2:0]  emit_r;
  logic        out_valid_r;
  word_t       out_word_r;
  logic        out_last_r;

  word_t va_r [4];
  word_t vb_r [4];
  word_t vc_r [4];
  word_t vd_r [4];
  word_t va_nxt [4];
  word_t vb_nxt [4];
  word_t vc_nxt [4];
  word_t vd_nxt [4];

  // memories
  word_t       msg_mem [16];
  word_t       cv_mem [8];
  word_t       msg_rdata_r;
  logic [3:0]  msg_ridx_r;
  word_t       cv_rdata_r;

  logic        msg_we;
  logic [3:0]  msg_waddr;
  logic        msg_re;
  logic [3:0]  msg_raddr;
  logic        cv_we;
  logic [2:0]  cv_waddr;
  word_t       cv_wdata;
  logic        cv_re;
  logic [2:0]  cv_raddr;

  logic        cfg_wr;
  logic [5:0]  len;
  logic [3:0]  nwords;
  logic        emit_last;
  logic        emit_go;
  word_t       emit_mask;

  logic [1:0]  off;
  logic [2:0]  room;
  logic [2:0]  take;
  logic        load_full;
  logic        load_put;
  logic [3:0]  lane_en;
  word_t       lane_mask;
  word_t       pend_nxt;

  logic        diag;
  logic        mix_done;
  logic [2:0]  g_next;
  logic [3:0]  round_next;
  word_t       msg_mask;
  word_t       msg_eff;
  quad_t       taps;
  quad_t       taps_new;
  mix_ctl_t    mix_ctl;

  logic [2:0]  step_m1;
  word_t       cv_src;
  word_t       fold_x;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DIGEST_LENGTH);
  assign prdata = (paddr[2] == REG_DIGEST_LENGTH) ? {26'd0, dl_r} : 32'd0;

  // channel signals
  assign in_msg.ready            = (state_r == S_IDLE);
  assign out_hash.valid          = out_valid_r;
  assign out_hash.hash_word      = out_word_r;
  assign out_hash.last_hash_word = out_last_r;

  // digest length derived values
  assign len       = eff_len(dl_r);
  assign nwords    = 4'(({1'b0, len} + 7'd3) >> 2);
  assign emit_last = (({1'b0, emit_r} + 4'd1) == nwords);
  assign emit_go   = !out_valid_r || out_hash.ready;

  // bytes of the last digest word beyond the digest length read as zero
  always_comb begin
    emit_mask = '0;
    for (int l = 0; l < 4; l++) begin
      emit_mask[8*l +: 8] = {8{(({1'b0, emit_r, 2'b00} + 6'(l)) < len)}};
    end
  end

  // byte packing: as many bytes as fit in the current buffer word
  assign off       = buf_r[1:0];
  assign room      = 3'd4 - {1'b0, off};
  assign take      = (rem_r < room) ? rem_r : room;
  assign load_full = (state_r == S_LOAD) && (rem_r != 3'd0) && buf_r[6];
  assign load_put  = (state_r == S_LOAD) && (rem_r != 3'd0) && !buf_r[6];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_en[l] = (3'(l) >= {1'b0, off}) && (3'(l) < ({1'b0, off} + take));
      lane_mask[8*l +: 8] = {8{lane_en[l]}};
    end
    pend_nxt = (pend_r & ~lane_mask) | ((item_word_r << {off, 3'b000}) & lane_mask);
  end

  // mix sequencing
  assign diag       = g_r[2];
  assign g_next     = g_r + 3'd1;
  assign round_next = (g_r == 3'd7) ? round_r + 4'd1 : round_r;
  assign mix_done   = (phase_r == 2'd3) && (g_r == 3'd7) && (round_r == LAST_ROUND);
  assign mix_ctl    = '{c_half: phase_r[0], second: phase_r[1]};

  // final block: bytes past the buffered count are padded with zero
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      msg_mask[8*l +: 8] =
        {8{!final_r || (({1'b0, msg_ridx_r, 2'b00} + 7'(l)) < buf_r)}};
    end
    msg_eff = msg_rdata_r & msg_mask;
  end

  // column taps or diagonal taps
  always_comb begin
    taps.a = va_r[0];
    taps.b = diag ? vb_r[1] : vb_r[0];
    taps.c = diag ? vc_r[2] : vc_r[0];
    taps.d = diag ? vd_r[3] : vd_r[0];
  end

  b2s_mix u_mix (
    .taps_i (taps),
    .msg_i  (msg_eff),
    .ctl_i  (mix_ctl),
    .taps_o (taps_new)
  );

  // write back the taps, rotate rows after each full g step
  always_comb begin
    word_t wa [4];
    word_t wb [4];
    word_t wc [4];
    word_t wd [4];
    wa = va_r;
    wb = vb_r;
    wc = vc_r;
    wd = vd_r;
    wa[0] = taps_new.a;
    if (diag) begin
      wb[1] = taps_new.b;
      wc[2] = taps_new.c;
      wd[3] = taps_new.d;
    end else begin
      wb[0] = taps_new.b;
      wc[0] = taps_new.c;
      wd[0] = taps_new.d;
    end
    if (phase_r == 2'd3) begin
      va_nxt = '{wa[1], wa[2], wa[3], wa[0]};
      vb_nxt = '{wb[1], wb[2], wb[3], wb[0]};
      vc_nxt = '{wc[1], wc[2], wc[3], wc[0]};
      vd_nxt = '{wd[1], wd[2], wd[3], wd[0]};
    end else begin
      va_nxt = wa;
      vb_nxt = wb;
      vc_nxt = wc;
      vd_nxt = wd;
    end
  end

  // chain word in flight: initial vector until the first fold writes memory
  assign step_m1 = 3'(step_r - 4'd1);
  assign cv_src  = fresh_r ? iv_param(step_m1, len) : cv_rdata_r;
  assign fold_x  = step_m1[2] ? (vb_r[step_m1[1:0]] ^ vd_r[step_m1[1:0]])
                              : (va_r[step_m1[1:0]] ^ vc_r[step_m1[1:0]]);

  // memory requests
  always_comb begin
    msg_we    = load_put;
    msg_waddr = buf_r[5:2];
    msg_re    = 1'b0;
    msg_raddr = SIGMA[4'd0][4'd0];
    cv_we     = 1'b0;
    cv_waddr  = step_m1;
    cv_wdata  = cv_src ^ fold_x;
    cv_re     = 1'b0;
    cv_raddr  = step_r[2:0];
    unique case (state_r)
      S_INIT: begin
        cv_re  = !step_r[3];
        msg_re = step_r[3];
      end
      S_MIX: begin
        if (phase_r == 2'd1) begin
          msg_re    = 1'b1;
          msg_raddr = SIGMA[round_r][{g_r, 1'b1}];
        end else if ((phase_r == 2'd3) && !mix_done) begin
          msg_re    = 1'b1;
          msg_raddr = SIGMA[round_next][{g_next, 1'b0}];
        end
      end
      S_FOLD: begin
        cv_re = !step_r[3];
        cv_we = (step_r != 4'd0);
      end
      S_ERD: begin
        cv_re    = emit_go;
        cv_raddr = emit_r;
      end
      default: begin
      end
    endcase
  end

  // message block memory
  always_ff @(posedge clk) begin
    if (msg_we) begin
      msg_mem[msg_waddr] <= pend_nxt;
    end
    if (msg_re) begin
      msg_rdata_r <= msg_mem[msg_raddr];
      msg_ridx_r  <= msg_raddr;
    end
  end

  // chain value memory
  always_ff @(posedge clk) begin
    if (cv_we) begin
      cv_mem[cv_waddr] <= cv_wdata;
    end
    if (cv_re) begin
      cv_rdata_r <= cv_mem[cv_raddr];
    end
  end

  // sequencer, working rows and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dl_r        <= DL_RESET;
      fresh_r     <= 1'b1;
      ctr_r       <= '0;
      buf_r       <= '0;
      final_r     <= 1'b0;
      rem_r       <= '0;
      last_r      <= 1'b0;
      step_r      <= '0;
      phase_r     <= '0;
      g_r         <= '0;
      round_r     <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load from the emit phase, release on transfer
      if (state_r == S_ELD) begin
        out_valid_r <= 1'b1;
        out_word_r  <= cv_rdata_r & emit_mask;
        out_last_r  <= emit_last;
      end else if (out_hash.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr) begin
        dl_r    <= pwdata[5:0];
        fresh_r <= 1'b1;
        ctr_r   <= '0;
        buf_r   <= '0;
        state_r <= S_IDLE;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_msg.valid) begin
              item_word_r <= in_msg.message_word;
              rem_r       <= (in_msg.valid_bytes > 3'd4) ? 3'd4 : in_msg.valid_bytes;
              last_r      <= in_msg.last_item;
              state_r     <= S_LOAD;
            end
          end
          S_LOAD: begin
            if (load_full) begin
              ctr_r   <= ctr_r + 64'd64;
              buf_r   <= '0;
              final_r <= 1'b0;
              step_r  <= '0;
              state_r <= S_INIT;
            end else if (load_put) begin
              pend_r      <= pend_nxt;
              buf_r       <= buf_r + 7'(take);
              rem_r       <= rem_r - take;
              item_word_r <= item_word_r >> {take, 3'b000};
            end else if (last_r) begin
              ctr_r   <= ctr_r + 64'(buf_r);
              final_r <= 1'b1;
              step_r  <= '0;
              state_r <= S_INIT;
            end else begin
              state_r <= S_IDLE;
            end
          end
          S_INIT: begin
            // constant half and counter/flag words on the first cycle
            if (step_r == 4'd0) begin
              vc_r <= '{IV[0], IV[1], IV[2], IV[3]};
              vd_r <= '{IV[4] ^ ctr_r[31:0], IV[5] ^ ctr_r[63:32],
                        IV[6] ^ {32{final_r}}, IV[7]};
            end else if (step_m1[2]) begin
              vb_r[step_m1[1:0]] <= cv_src;
            end else begin
              va_r[step_m1[1:0]] <= cv_src;
            end
            if (step_r[3]) begin
              phase_r <= '0;
              g_r     <= '0;
              round_r <= '0;
              state_r <= S_MIX;
            end else begin
              step_r <= step_r + 4'd1;
            end
          end
          S_MIX: begin
            va_r    <= va_nxt;
            vb_r    <= vb_nxt;
            vc_r    <= vc_nxt;
            vd_r    <= vd_nxt;
            phase_r <= phase_r + 2'd1;
            if (phase_r == 2'd3) begin
              g_r     <= g_next;
              round_r <= round_next;
            end
            if (mix_done) begin
              step_r  <= '0;
              state_r <= S_FOLD;
            end
          end
          S_FOLD: begin
            if (step_r[3]) begin
              fresh_r <= 1'b0;
              emit_r  <= '0;
              state_r <= final_r ? S_ERD : S_LOAD;
            end else begin
              step_r <= step_r + 4'd1;
            end
          end
          S_ERD: begin
            if (emit_go) begin
              state_r <= S_ELD;
            end
          end
          S_ELD: begin
            if (emit_last) begin
              fresh_r <= 1'b1;
              ctr_r   <= '0;
              buf_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              emit_r  <= emit_r + 3'd1;
              state_r <= S_ERD;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  // checks
  a_buf_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_r <= 7'd64)
    else $error("buffered byte count above one block");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_ELD))
    else $error("output register loaded outside the emit phase");

  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT && step_r == 4'd0 && !final_r) |-> (buf_r == 7'd0))
    else $error("intermediate compression started without emptying the buffer");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ELD) |-> ({1'b0, emit_r} < nwords))
    else $error("digest word index past the digest length");

endmodule

// ===== rtl/core/b2s_mix.sv =====
// one quarter of the g function: one add chain and one xor-rotate per call
module b2s_mix import b2s_pkg::*; (
  input  quad_t    taps_i,
  input  word_t    msg_i,
  input  mix_ctl_t ctl_i,
  output quad_t    taps_o
);

  word_t d_x;
  word_t b_x;

  // a/d half or c/b half, rotation amounts by pass
  always_comb begin
    taps_o = taps_i;
    d_x    = '0;
    b_x    = '0;
    if (!ctl_i.c_half) begin
      taps_o.a = taps_i.a + taps_i.b + msg_i;
      d_x      = taps_i.d ^ taps_o.a;
      taps_o.d = ctl_i.second ? ((d_x >> ROT_D2) | (d_x << (32 - ROT_D2)))
                              : ((d_x >> ROT_D1) | (d_x << (32 - ROT_D1)));
    end else begin
      taps_o.c = taps_i.c + taps_i.d;
      b_x      = taps_i.b ^ taps_o.c;
      taps_o.b = ctl_i.second ? ((b_x >> ROT_B2) | (b_x << (32 - ROT_B2)))
                              : ((b_x >> ROT_B1) | (b_x << (32 - ROT_B1)));
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// blake2s engine testbench: digest predictor, scoreboard and top-level stimulus
package tb_blake2s_pkg;

  // configuration register indexes
  typedef enum int unsigned {
    REG_DIGEST_LENGTH = 0,
    REG_UNMAPPED      = 1
  } cfg_reg_e;

  localparam bit [31:0] CHAIN_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // message word order per round
  localparam bit [3:0] MSG_SCHED [10][16] = '{
    '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
    '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
    '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
    '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
    '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
    '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
    '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
    '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
    '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
    '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
  };

  // column then diagonal taps of the working vector
  localparam bit [3:0] MIX_TAPS [8][4] = '{
    '{0, 4,  8, 12}, '{1, 5,  9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
    '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7,  8, 13}, '{3, 4,  9, 14}
  };

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    bit [31:0] word;
    bit        last;
  } digest_word_t;

  class digest_scoreboard;
    bit [5:0]     dlen;
    bit [31:0]    chain [8];
    bit [63:0]    byte_cnt;
    bit [31:0]    blk [16];
    int unsigned  fill;
    digest_word_t expected_q [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      dlen = 6'd32;
      restart();
    endfunction

    // digest bytes actually produced: zero acts as one, clipped at 32
    function int unsigned used_len();
      if (dlen == 6'd0) return 1;
      if (dlen > 6'd32) return 32;
      return dlen;
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = CHAIN_IV[i];
      chain[0] ^= 32'h01010000 | used_len();
      byte_cnt = '0;
      foreach (blk[i]) blk[i] = '0;
      fill = 0;
    endfunction

    function void write_register(cfg_reg_e idx, bit [31:0] data);
      if (idx != REG_DIGEST_LENGTH) return;
      dlen = data[5:0];
      restart();
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress(bit final_blk);
      bit [31:0] v [16];
      bit [31:0] a, b, c, d;
      for (int i = 0; i < 8; i++) begin
        v[i] = chain[i];
        v[i + 8] = CHAIN_IV[i];
      end
      v[12] ^= byte_cnt[31:0];
      v[13] ^= byte_cnt[63:32];
      if (final_blk) begin
        v[14] = ~v[14];
      end
      for (int r = 0; r < 10; r++) begin
        for (int g = 0; g < 8; g++) begin
          a = v[MIX_TAPS[g][0]];
          b = v[MIX_TAPS[g][1]];
          c = v[MIX_TAPS[g][2]];
          d = v[MIX_TAPS[g][3]];
          a = a + b + blk[MSG_SCHED[r][2 * g]];
          d = rotr(d ^ a, 16);
          c = c + d;
          b = rotr(b ^ c, 12);
          a = a + b + blk[MSG_SCHED[r][2 * g + 1]];
          d = rotr(d ^ a, 8);
          c = c + d;
          b = rotr(b ^ c, 7);
          v[MIX_TAPS[g][0]] = a;
          v[MIX_TAPS[g][1]] = b;
          v[MIX_TAPS[g][2]] = c;
          v[MIX_TAPS[g][3]] = d;
        end
      end
      for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i + 8];
    endfunction

    // a full block is only compressed once another byte turns up
    function void pack_byte(bit [7:0] byt);
      if (fill >= 64) begin
        byte_cnt += 64;
        compress(1'b0);
        fill = 0;
      end
      blk[fill / 4][8 * (fill % 4) +: 8] = byt;
      fill++;
    endfunction

    // accepted message transfer: pack, and on the last one finalise
    function void note_word(bit [31:0] word, bit [2:0] vb, bit last);
      int unsigned nbytes, len, nwords, rem;
      bit [31:0] hw;
      nbytes = (vb > 3'd4) ? 4 : vb;
      for (int i = 0; i < nbytes; i++) pack_byte(word[8 * i +: 8]);
      if (!last) return;
      byte_cnt += fill;
      for (int pos = fill; pos < 64; pos++) blk[pos / 4][8 * (pos % 4) +: 8] = 8'h00;
      compress(1'b1);
      len = used_len();
      nwords = (len + 3) / 4;
      for (int i = 0; i < nwords; i++) begin
        hw = chain[i];
        rem = len - 4 * i;
        if (rem < 4) begin
          hw &= (32'd1 << (8 * rem)) - 32'd1;
        end
        expected_q.push_back('{word: hw, last: (i + 1 == nwords)});
      end
      restart();
    endfunction

    function void flag(string what, logic [31:0] expv, logic [31:0] actv);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("mismatch in %s: expected %h, got %h", what, expv, actv);
      end
    endfunction

    function void check_digest(logic [31:0] word, logic last);
      digest_word_t exp_w;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("digest word %h (last %b) arrived with none expected", word, last);
        end
        return;
      end
      exp_w = expected_q.pop_front();
      if (word !== exp_w.word) begin
        flag("hash_word", exp_w.word, word);
      end
      if (last !== exp_w.last) begin
        flag("last_hash_word", 32'(exp_w.last), 32'(last));
      end
    endfunction
  endclass

endpackage

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b2s_pkg::*;
  import tb_blake2s_pkg::*;

  localparam bit [2:0]    DL_ADDR       = 3'(4 * REG_DIGEST_LENGTH);
  localparam bit [2:0]    UNMAPPED_ADDR = 3'(4 * REG_UNMAPPED);
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned PHASE_ITEMS   = 15;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned ABANDON_PHASE = 4;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  digest_scoreboard sb = new();

  b2s_in_if  msg_if ();
  b2s_out_if hash_if ();

  blake2s_hash_engine_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_msg   (msg_if),
    .out_hash (hash_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 10 ns clock
  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    hash_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hash_if.ready <= 1'b0;
        hold_left--;
      end else begin
        hash_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // result checking and watchdog on cycles without any transfer
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (hash_if.valid && hash_if.ready) begin
          sb.check_digest(hash_if.hash_word, hash_if.last_hash_word);
        end
        if ((msg_if.valid && msg_if.ready) || (hash_if.valid && hash_if.ready) ||
            (psel && penable)) begin
          quiet_cycles = 0;
        end else begin
          quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", quiet_cycles);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // one message transfer, called and returning at a falling edge
  task automatic send_word(input bit [31:0] word, input bit [2:0] vb, input bit last);
    while ($urandom_range(99) < snd_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(negedge clk);
    end
    msg_if.valid        <= 1'b1;
    msg_if.message_word <= word;
    msg_if.valid_bytes  <= vb;
    msg_if.last_item    <= last;
    do @(posedge clk); while (!msg_if.ready);
    sb.note_word(word, vb, last);
    @(negedge clk);
  endtask

  // random message: mostly full words, the odd short or oversized byte count
  task automatic send_message(inout int unsigned items);
    int unsigned nwords;
    bit [31:0]   word;
    bit [2:0]    vb;
    nwords = ($urandom_range(9) == 0) ? $urandom_range(34, 16) : $urandom_range(8);
    for (int k = 0; k < nwords; k++) begin
      case ($urandom_range(9))
        0: word = 32'h0;
        1: word = 32'hFFFF_FFFF;
        default: word = $urandom();
      endcase
      vb = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'd4;
      send_word(word, vb, 1'b0);
    end
    send_word($urandom(), 3'($urandom_range(7)), 1'b1);
    items += nwords + 1;
  endtask

  // drop valid, wait for outstanding digests, then let the engine go quiet
  task automatic settle();
    msg_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input bit [2:0] addr, input bit [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(cfg_reg_e'(addr / 4), data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // read back the digest length register and compare with the prediction
  task automatic check_dig_len();
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= DL_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (rd !== {26'd0, sb.dlen}) begin
      sb.flag("digest length readback", {26'd0, sb.dlen}, rd);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int unsigned items;
    bit [5:0]    dl_list [NUM_PHASES];
    dl_list = '{6'd0, 6'd63, 6'd5, 6'd1, 6'd33, 6'd17};

    rst_n               = 1'b0;
    msg_if.valid        = 1'b0;
    msg_if.message_word = '0;
    msg_if.valid_bytes  = '0;
    msg_if.last_item    = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty message, "abc", short and oversized byte counts
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h0063_6261, 3'd3, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b0);
    send_word(32'h0, 3'd1, 1'b0);
    send_word(32'h8000_0001, 3'd6, 1'b1);
    // exactly one block, closed by a zero-byte last transfer
    for (int k = 0; k < 16; k++) begin
      send_word(32'h0302_0100 + 32'h0404_0404 * k, 3'd4, 1'b0);
    end
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    settle();

    // a write to an unmapped index must change nothing
    cfg_write(UNMAPPED_ADDR, $urandom());
    check_dig_len();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // leave a message half done so the register write has to abandon it
      if (p == ABANDON_PHASE) begin
        for (int k = 0; k < 3; k++) send_word($urandom(), 3'($urandom_range(7)), 1'b0);
        settle();
      end
      cfg_write(DL_ADDR, ($urandom() & 32'hFFFF_FFC0) | dl_list[p]);
      check_dig_len();
      case (p % 4)
        0: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          snd_idle_pct  = 49;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 49;
        end
        default: begin
          snd_idle_pct  = 32;
          rcv_stall_pct = 32;
        end
      endcase
      // back-pressure: receiver holds off while the sender keeps offering
      if (p == 0) begin
        hold_left = HOLD_CYCLES;
      end
      items = 0;
      while (items < PHASE_ITEMS) send_message(items);
      settle();
    end

    if (sb.expected_q.size() != 0) begin
      $display("%0d digest words never arrived", sb.expected_q.size());
    end
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/b2s_pkg.sv
rtl/core/b2s_in_if.sv
rtl/core/b2s_out_if.sv
rtl/core/b2s_mix.sv
rtl/core/blake2s_hash_engine_core.sv
tb/sv/tb_top.sv
